// File: rtl/core/mif_pkg.sv
// constants, widths and types for the fermat modular inverse core
// no dependencies; imported by every module of the core
package mif_pkg;

	localparam int IN_W = 13;
	localparam int DATA_W = 16;
	localparam int MODULUS = 4621;
	localparam int RES_W = $clog2(MODULUS);
	localparam int EXP_W = 13;
	localparam logic [EXP_W-1:0] EXP_BITS = EXP_W'(MODULUS - 2);
	localparam int STEPS = 2 * EXP_W;

	// reducer input width: covers a full product and the offset input value
	localparam int RED_W = (2 * RES_W > IN_W + 1) ? 2 * RES_W : IN_W + 1;
	localparam int BAR_M = (2 ** RED_W) / MODULUS;
	localparam int BAR_W = $clog2(BAR_M + 1);
	localparam int QUO_W = RED_W - RES_W + 1;

	// multiple of the modulus that lifts any signed input to a nonnegative value
	localparam int IN_OFFSET = MODULUS * ((2 ** (IN_W - 1) + MODULUS - 1) / MODULUS);
	localparam int HALF = MODULUS / 2;

	typedef struct packed {
		logic             valid;
		logic [RES_W-1:0] base;
	} tag_t;

endpackage

// File: rtl/core/mif_reduce.sv
// two-stage barrett reduction of a nonnegative value modulo MODULUS
// depends on mif_pkg
module mif_reduce
	import mif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tag_t             in_tag,
	input  logic [RED_W-1:0] p,
	output tag_t             out_tag,
	output logic [RES_W-1:0] r
);

	localparam int MP_W = RED_W + BAR_W;
	localparam int QM_W = QUO_W + RES_W;

	logic [MP_W-1:0]  mprod;
	logic [QUO_W-1:0] quo_s1;
	logic [RES_W:0]   p_s1;
	logic             valid_s1;
	logic [RES_W-1:0] base_s1;
	logic [RES_W:0]   qm;
	logic [RES_W:0]   diff;
	logic [RES_W:0]   fix;
	logic             valid_s2;
	logic [RES_W-1:0] base_s2;
	logic [RES_W-1:0] r_s2;

	// quotient estimate is at most one below the true quotient
	assign mprod = MP_W'(p) * MP_W'(BAR_M);

	// remainder is below twice the modulus, so the low bits suffice
	assign qm = (RES_W+1)'(QM_W'(quo_s1) * QM_W'(MODULUS));
	assign diff = p_s1 - qm;
	assign fix = (diff >= (RES_W+1)'(MODULUS)) ? diff - (RES_W+1)'(MODULUS) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_tag.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1 <= QUO_W'(mprod >> RED_W);
			p_s1 <= p[RES_W:0];
			base_s1 <= in_tag.base;
			r_s2 <= fix[RES_W-1:0];
			base_s2 <= base_s1;
		end
	end

	assign out_tag = '{valid: valid_s2, base: base_s2};
	assign r = r_s2;

endmodule

// File: rtl/core/mif_modmul.sv
// three-stage modular multiplier: product register, then barrett reduction
// depends on mif_pkg and mif_reduce
module mif_modmul
	import mif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tag_t             in_tag,
	input  logic [RES_W-1:0] x,
	input  logic [RES_W-1:0] y,
	output tag_t             out_tag,
	output logic [RES_W-1:0] z
);

	logic [2*RES_W-1:0] prod_s1;
	logic               valid_s1;
	logic [RES_W-1:0]   base_s1;
	tag_t               tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*RES_W)'(x) * (2*RES_W)'(y);
			base_s1 <= in_tag.base;
		end
	end

	assign tag_s1 = '{valid: valid_s1, base: base_s1};

	mif_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (tag_s1),
		.p       (RED_W'(prod_s1)),
		.out_tag (out_tag),
		.r       (z)
	);

endmodule

// File: rtl/core/mif_outbuf.sv
// two-entry output buffer that keeps the pipeline running while a result waits
// depends on mif_pkg
module mif_outbuf
	import mif_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [IN_W-1:0] in_data,
	output logic            full,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [IN_W-1:0] m_data
);

	logic [1:0]      count_q;
	logic [IN_W-1:0] ent0_q;
	logic [IN_W-1:0] ent1_q;
	logic            pop;

	assign pop = m_tvalid && m_tready;
	assign m_tvalid = (count_q != 2'd0);
	assign full = (count_q == 2'd2);
	assign m_data = ent0_q;

	// a push never arrives while full, the pipeline is stalled then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case (count_q)
				2'd0: begin
					if (in_valid) count_q <= 2'd1;
				end
				2'd1: begin
					if (in_valid && !pop) count_q <= 2'd2;
					else if (!in_valid && pop) count_q <= 2'd0;
				end
				2'd2: begin
					if (pop) count_q <= 2'd1;
				end
				default: begin
					count_q <= 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (count_q)
			2'd0: begin
				if (in_valid) ent0_q <= in_data;
			end
			2'd1: begin
				if (in_valid && pop) ent0_q <= in_data;
				else if (in_valid) ent1_q <= in_data;
			end
			2'd2: begin
				if (pop) ent0_q <= ent1_q;
			end
			default: begin
				ent0_q <= ent0_q;
			end
		endcase
	end

endmodule

// File: rtl/core/modular_inverse_fermat_core.sv
// top level of the fermat modular inverse core: a^(MODULUS-2) mod MODULUS, centered
// depends on mif_pkg, mif_reduce, mif_modmul and mif_outbuf
//
// channel | direction | handshake          | payload
// s_*     | in        | s_tvalid/s_tready  | s_tdata[12:0] residue_in (signed)
// m_*     | out       | m_tvalid/m_tready  | m_tdata[12:0] inverse_out (signed)
//
// one item per cycle while the output buffer is not full; a result passes through
// input registering and reduction, 26 chained three-stage modular multipliers (square
// and multiply per exponent bit), the centering register and the output buffer.
// reset clears all valid bits and the output buffer; no stored state otherwise.
// a stall holds the whole pipeline only once the two-entry output buffer is full.
module modular_inverse_fermat_core
	import mif_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // [12:0] residue_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata   // [12:0] inverse_out
);

	logic             en;
	logic             full;
	logic             valid_s1;
	logic [RED_W-1:0] u_s1;
	logic [RED_W-1:0] u_next;
	tag_t             red_tag;
	logic [RES_W-1:0] red_r;
	tag_t             tag [STEPS+1];
	logic [RES_W-1:0] acc [STEPS+1];
	logic [IN_W-1:0]  cen;
	logic             valid_c;
	logic [IN_W-1:0]  cen_c;
	logic [IN_W-1:0]  out_data;

	assign en = !full;
	assign s_tready = en;

	assign u_next = RED_W'($signed(s_tdata[IN_W-1:0])) + RED_W'(IN_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_next;
		end
	end

	mif_reduce u_in_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  ('{valid: valid_s1, base: '0}),
		.p       (u_s1),
		.out_tag (red_tag),
		.r       (red_r)
	);

	// the reduced input becomes the base carried along the chain
	assign tag[0] = '{valid: red_tag.valid, base: red_r};
	assign acc[0] = RES_W'(1);

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [RES_W-1:0] y;
		if (j % 2 == 0) begin : g_sq
			assign y = acc[j];
		end else if (EXP_BITS[EXP_W-1-j/2]) begin : g_mul
			assign y = tag[j].base;
		end else begin : g_one
			assign y = RES_W'(1);
		end
		mif_modmul u_mul (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_tag  (tag[j]),
			.x       (acc[j]),
			.y       (y),
			.out_tag (tag[j+1]),
			.z       (acc[j+1])
		);
	end

	assign cen = (acc[STEPS] > RES_W'(HALF))
		? IN_W'(acc[STEPS]) - IN_W'(MODULUS) : IN_W'(acc[STEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_c <= 1'b0;
		end else if (en) begin
			valid_c <= tag[STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cen_c <= cen;
		end
	end

	mif_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c && en),
		.in_data  (cen_c),
		.full     (full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_data   (out_data)
	);

	assign m_tdata = {{(DATA_W-IN_W){1'b0}}, out_data};

endmodule

// File: rtl/core/mif_checker.sv
// port-level checks for the fermat modular inverse core, bound to the top level
// depends on mif_pkg and modular_inverse_fermat_core
module mif_checker
	import mif_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [DATA_W-1:0] s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// results are always centered representatives
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[IN_W-1:0]) <= HALF
			&& $signed(m_tdata[IN_W-1:0]) >= -((MODULUS - 1) / 2)))
		else $error("result outside centered range");

	// input side only stalls when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("waiting result changed or dropped");

	// nothing comes out right after reset is released
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result present after reset");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DATA_W-1:IN_W] == '0)
		else $error("padding bits of result not zero");

endmodule

bind modular_inverse_fermat_core mif_checker u_mif_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/tb.sv
// self-checking bench for modular_inverse_fermat_core: residues go in, centered inverses come out
// depends on mif_pkg and the core rtl; predicts each inverse by square-and-multiply in the bench
`timescale 1ns / 1ps

module tb;
	import mif_pkg::*;

	localparam int RANDOM_ITEMS = 1350;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 600;
	localparam int STEADY_FROM = 200;
	localparam int STEADY_TO = 500;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int DIRECTED_ROWS = 20;

	typedef struct packed {
		logic [IN_W-1:0] residue;
		logic            known;
		logic [IN_W-1:0] inverse;
	} inv_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;  // [12:0] residue_in
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;  // [12:0] inverse_out

	logic [IN_W-1:0] pending_inverses [$];
	logic [IN_W-1:0] oldest_inverse;
	int              accepted;
	int              mismatches;
	int              cycles;
	bit              hold_done;

	// rows with a typed inverse are easy to check by hand: 2 * 2311 = q + 1, 2310 * 2 = q - 1
	inv_row_t directed_rows [DIRECTED_ROWS] = '{
		'{IN_W'(0),     1'b1, IN_W'(0)},
		'{IN_W'(1),     1'b1, IN_W'(1)},
		'{IN_W'(-1),    1'b1, IN_W'(-1)},
		'{IN_W'(2),     1'b1, IN_W'(-2310)},
		'{IN_W'(-2),    1'b1, IN_W'(2310)},
		'{IN_W'(2310),  1'b1, IN_W'(-2)},
		'{IN_W'(-2310), 1'b1, IN_W'(2)},
		'{IN_W'(2311),  1'b1, IN_W'(2)},
		'{IN_W'(-2311), 1'b1, IN_W'(-2)},
		'{IN_W'(0),     1'b1, IN_W'(0)},
		'{IN_W'(4095),  1'b0, IN_W'(0)},
		'{IN_W'(-4096), 1'b0, IN_W'(0)},
		'{IN_W'(4094),  1'b0, IN_W'(0)},
		'{IN_W'(2048),  1'b0, IN_W'(0)},
		'{IN_W'(-2048), 1'b0, IN_W'(0)},
		'{IN_W'(3),     1'b0, IN_W'(0)},
		'{IN_W'(-3),    1'b0, IN_W'(0)},
		'{IN_W'(2309),  1'b0, IN_W'(0)},
		'{IN_W'(-2309), 1'b0, IN_W'(0)},
		'{IN_W'(1000),  1'b0, IN_W'(0)}
	};

	modular_inverse_fermat_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// a^(q-2) mod q, returned as the centered representative
	function automatic logic [IN_W-1:0] fermat_inverse(logic [IN_W-1:0] residue);
		int              lifted;
		longint          power;
		logic [EXP_W-1:0] exponent;
		int              centered;
		int              bit_idx;
		lifted = $signed(residue);
		lifted = lifted % MODULUS;
		if (lifted < 0) begin
			lifted += MODULUS;
		end
		exponent = EXP_W'(MODULUS - 2);
		power = 1 % MODULUS;
		for (bit_idx = EXP_W - 1; bit_idx >= 0; bit_idx--) begin
			power = (power * power) % MODULUS;
			if (exponent[bit_idx]) begin
				power = (power * lifted) % MODULUS;
			end
		end
		centered = int'(power);
		if (power > MODULUS / 2) begin
			centered -= MODULUS;
		end
		return IN_W'(centered);
	endfunction

	function automatic bit steady_stretch();
		return accepted >= STEADY_FROM && accepted < STEADY_TO;
	endfunction

	task automatic offer_residue(logic [IN_W-1:0] residue, logic known,
			logic [IN_W-1:0] inverse);
		while (!steady_stretch() && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'(residue);
		do @(posedge clk); while (!s_tready);
		pending_inverses.push_back(known ? inverse : fermat_inverse(residue));
		accepted++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("modular_inverse_fermat_core verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_inverses.size() == 0) begin
				$error("inverse_out: no item expected, got %0d", $signed(m_tdata[IN_W-1:0]));
				mismatches++;
			end else begin
				oldest_inverse = pending_inverses.pop_front();
				if (m_tdata[IN_W-1:0] !== oldest_inverse) begin
					$error("inverse_out: expected %0d, got %0d", $signed(oldest_inverse),
						$signed(m_tdata[IN_W-1:0]));
					mismatches++;
				end
			end
		end
	end

	// receiver: random back-pressure, one long hold-off so the pipeline fills and stalls
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= steady_stretch() || ($urandom_range(99) >= 15);
			end
		end
	end

	initial begin
		logic [IN_W-1:0] pick;
		int unsigned     sel;
		int              row_idx;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		accepted = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++) begin
			offer_residue(directed_rows[row_idx].residue, directed_rows[row_idx].known,
				directed_rows[row_idx].inverse);
		end

		// mostly centered residues, some raw 13-bit patterns, a few edge values
		repeat (RANDOM_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				pick = IN_W'($urandom_range(2 * HALF) - HALF);
			end else if (sel < 90) begin
				pick = IN_W'($urandom);
			end else begin
				case ($urandom_range(6))
					0: pick = IN_W'(0);
					1: pick = IN_W'(1);
					2: pick = IN_W'(-1);
					3: pick = IN_W'(HALF);
					4: pick = IN_W'(-HALF);
					5: pick = IN_W'(4095);
					default: pick = IN_W'(-4096);
				endcase
			end
			offer_residue(pick, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_inverses.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("modular_inverse_fermat_core verification clean");
		end else begin
			$display("modular_inverse_fermat_core verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/mif_pkg.sv
rtl/core/mif_reduce.sv
rtl/core/mif_modmul.sv
rtl/core/mif_outbuf.sv
rtl/core/modular_inverse_fermat_core.sv
rtl/core/mif_checker.sv
sim/tb.sv
